// ----- rtl/core/pam_pkg.sv -----
// Shared constants, types and codes of the six-channel peak amplitude meter.
package pam_pkg;

   localparam int CHANNELS    = 6;
   localparam int SAMPLE_BITS = 12;
   localparam int FIELD_COUNT = 6;
   localparam int AMP_BITS    = 12;
   localparam int TIME_BITS   = 32;
   localparam int DIV_BITS    = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam int REQ_DATA_BITS = ((FIELD_COUNT * SAMPLE_BITS + TIME_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((FIELD_COUNT * AMP_BITS + 7) / 8) * 8;

   // smoothing: (4*old + peak) / 5 through a reciprocal multiply
   localparam int SUM_BITS    = SAMPLE_BITS + 3;
   localparam int RECIP_SHIFT = SUM_BITS + 3;
   localparam int RECIP_BITS  = RECIP_SHIFT - 1;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_FIVE =
      RECIP_BITS'((2 ** RECIP_SHIFT) / 5 + 1);

   // amplitude: diff * 100 / divisor
   localparam int NUM_BITS = SAMPLE_BITS + 7;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);
   localparam logic [NUM_BITS-1:0] AMP_SCALE = NUM_BITS'(100);
   localparam logic [AMP_BITS-1:0] AMP_MAX   = '1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIVISOR_FIRST    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIVISOR_OTHER    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PEAK_MIDPOINT    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_MS        = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CORRECTION_LIMIT = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLOOR_LIMIT      = 3'd5;

   // register reset values
   localparam logic [DIV_BITS-1:0]    RST_DIVISOR_FIRST    = 16'd1154;
   localparam logic [DIV_BITS-1:0]    RST_DIVISOR_OTHER    = 16'd1120;
   localparam logic [SAMPLE_BITS-1:0] RST_PEAK_MIDPOINT    = SAMPLE_BITS'(2048);
   localparam logic [15:0]            RST_WINDOW_MS        = 16'd40;
   localparam logic [AMP_BITS-1:0]    RST_CORRECTION_LIMIT = AMP_BITS'(50);
   localparam logic [AMP_BITS-1:0]    RST_FLOOR_LIMIT      = AMP_BITS'(5);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [AMP_BITS-1:0]    amp_type;
   typedef amp_type [FIELD_COUNT-1:0] amp_vec_type;

   typedef struct packed {
      logic accept;
      logic close;
   } lane_ctrl_type;

   typedef struct packed {
      logic [DIV_BITS-1:0] divisor;
      sample_type          midpoint;
      amp_type             correction_limit;
      amp_type             floor_limit;
   } lane_cfg_type;

   typedef enum logic [2:0] {
      LN_IDLE,
      LN_SUM,
      LN_MUL,
      LN_SCALE,
      LN_DIV,
      LN_POST,
      LN_DONE
   } lane_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_BUSY,
      TOP_HOLD
   } top_state_type;

endpackage

// ----- rtl/core/pam_lane.sv -----
// One channel lane: peak tracking, smoothing and serial amplitude division.
module pam_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  pam_pkg::lane_ctrl_type ctrl,
   input  pam_pkg::sample_type   sample,
   input  pam_pkg::lane_cfg_type cfg,
   output pam_pkg::amp_type      amplitude,
   output logic                  done
);

   pam_pkg::lane_state_type state_ff, state_in;

   pam_pkg::sample_type peak_high_ff, peak_low_ff;
   pam_pkg::sample_type smooth_high_ff, smooth_low_ff;
   logic [pam_pkg::SUM_BITS-1:0]  sum_high_ff, sum_low_ff;
   logic [pam_pkg::PROD_BITS-1:0] prod_high_ff, prod_low_ff;
   logic [pam_pkg::DIV_BITS-1:0]  rem_ff;
   logic [pam_pkg::NUM_BITS-1:0]  quo_ff;
   logic [pam_pkg::CNT_BITS-1:0]  count_ff;
   pam_pkg::amp_type              amp_ff;

   pam_pkg::sample_type          new_high, new_low, diff;
   logic [pam_pkg::NUM_BITS-1:0] num;
   logic [pam_pkg::DIV_BITS:0]   trial;
   logic                         take;
   pam_pkg::amp_type             amp_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pam_pkg::LN_IDLE:  if (ctrl.close) state_in = pam_pkg::LN_SUM;
         pam_pkg::LN_SUM:   state_in = pam_pkg::LN_MUL;
         pam_pkg::LN_MUL:   state_in = pam_pkg::LN_SCALE;
         pam_pkg::LN_SCALE: state_in = pam_pkg::LN_DIV;
         pam_pkg::LN_DIV: begin
            if (count_ff == pam_pkg::CNT_BITS'(pam_pkg::NUM_BITS - 1))
               state_in = pam_pkg::LN_POST;
         end
         pam_pkg::LN_POST:  state_in = pam_pkg::LN_DONE;
         pam_pkg::LN_DONE:  state_in = pam_pkg::LN_IDLE;
         default:           state_in = pam_pkg::LN_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == pam_pkg::LN_DONE);
   end

   assign amplitude = amp_ff;

   always_comb begin
      new_high = prod_high_ff[pam_pkg::RECIP_SHIFT +: pam_pkg::SAMPLE_BITS];
      new_low  = prod_low_ff[pam_pkg::RECIP_SHIFT +: pam_pkg::SAMPLE_BITS];
      diff     = (new_high > new_low) ? (new_high - new_low) : '0;
      num      = pam_pkg::NUM_BITS'(diff) * pam_pkg::AMP_SCALE;
      trial    = {rem_ff, quo_ff[pam_pkg::NUM_BITS-1]};
      take     = (trial >= {1'b0, cfg.divisor});
   end

   always_comb begin
      logic [pam_pkg::NUM_BITS-1:0] a;
      a = quo_ff;
      if ((a != '0) && (a < pam_pkg::NUM_BITS'(cfg.correction_limit)))
         a = a - 1'b1;
      if (a < pam_pkg::NUM_BITS'(cfg.floor_limit))
         a = '0;
      if (cfg.divisor == '0)
         amp_in = pam_pkg::AMP_MAX;
      else if (a > pam_pkg::NUM_BITS'(pam_pkg::AMP_MAX))
         amp_in = pam_pkg::AMP_MAX;
      else
         amp_in = a[pam_pkg::AMP_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pam_pkg::LN_IDLE;
         peak_high_ff   <= pam_pkg::RST_PEAK_MIDPOINT;
         peak_low_ff    <= pam_pkg::RST_PEAK_MIDPOINT;
         smooth_high_ff <= '0;
         smooth_low_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (ctrl.accept) begin
            if (sample > peak_high_ff) peak_high_ff <= sample;
            if (sample < peak_low_ff)  peak_low_ff  <= sample;
         end else if (state_ff == pam_pkg::LN_SUM) begin
            peak_high_ff <= cfg.midpoint;
            peak_low_ff  <= cfg.midpoint;
         end
         if (state_ff == pam_pkg::LN_SCALE) begin
            smooth_high_ff <= new_high;
            smooth_low_ff  <= new_low;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         pam_pkg::LN_SUM: begin
            sum_high_ff <= {1'b0, smooth_high_ff, 2'b00} + pam_pkg::SUM_BITS'(peak_high_ff);
            sum_low_ff  <= {1'b0, smooth_low_ff, 2'b00} + pam_pkg::SUM_BITS'(peak_low_ff);
         end
         pam_pkg::LN_MUL: begin
            prod_high_ff <= pam_pkg::PROD_BITS'(sum_high_ff) * pam_pkg::PROD_BITS'(pam_pkg::RECIP_FIVE);
            prod_low_ff  <= pam_pkg::PROD_BITS'(sum_low_ff) * pam_pkg::PROD_BITS'(pam_pkg::RECIP_FIVE);
         end
         pam_pkg::LN_SCALE: begin
            rem_ff   <= '0;
            quo_ff   <= num;
            count_ff <= '0;
         end
         pam_pkg::LN_DIV: begin
            if (take)
               rem_ff <= pam_pkg::DIV_BITS'(trial - {1'b0, cfg.divisor});
            else
               rem_ff <= trial[pam_pkg::DIV_BITS-1:0];
            quo_ff   <= {quo_ff[pam_pkg::NUM_BITS-2:0], take};
            count_ff <= count_ff + 1'b1;
         end
         pam_pkg::LN_POST: amp_ff <= amp_in;
         default: ;
      endcase
   end

endmodule

// ----- rtl/core/pam_merge.sv -----
// Result stage: gathers the lane amplitudes into the output item register.
module pam_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  pam_pkg::amp_vec_type               amps,
   output logic                               free,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pam_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   logic                              valid_ff;
   logic [pam_pkg::RSP_DATA_BITS-1:0] data_ff;

   assign free       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= pam_pkg::RSP_DATA_BITS'(amps);
   end

endmodule

// ----- rtl/core/six_channel_peak_amplitude_meter_unit.sv -----
// Top level of the six-channel peak amplitude meter.
//
//  channel | dir | ports                          | item
//  req     | in  | req_tvalid/tready/tdata[103:0] | six samples and a timestamp
//  rsp     | out | rsp_tvalid/tready/tdata[71:0]  | six amplitudes, one per window close
//  csr     | in  | csr_wr_en/index/wdata          | register write, no wait
//
//  A scan that does not close the window is taken while ready stays high.
//  A closing scan keeps ready low through sum, reciprocal multiply, scale,
//  the per-lane restoring divider, post and hand-off.
//  When the result register is still full at that point, ready stays low until it drains.
//  Synchronous active-high reset; no clearing pass.
module six_channel_peak_amplitude_meter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sample_0..sample_5 (12 b each), now_ms (32 b)
   input  logic [pam_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // amplitude_0..amplitude_5 (12 b each)
   output logic [pam_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [pam_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pam_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   pam_pkg::top_state_type state_ff, state_in;

   logic [pam_pkg::DIV_BITS-1:0]  divisor_first_ff, divisor_other_ff;
   pam_pkg::sample_type           midpoint_ff;
   logic [15:0]                   window_ff;
   pam_pkg::amp_type              correction_ff, floor_ff;
   logic [pam_pkg::TIME_BITS-1:0] last_close_ff;

   logic                          accept, close, all_done, free, load;
   logic [pam_pkg::TIME_BITS-1:0] now, elapsed;
   logic [pam_pkg::FIELD_COUNT-1:0] lane_done;
   pam_pkg::amp_vec_type          amps;
   pam_pkg::lane_ctrl_type        ctrl;

   assign accept  = req_tvalid && req_tready;
   assign now     = req_tdata[pam_pkg::FIELD_COUNT*pam_pkg::SAMPLE_BITS +: pam_pkg::TIME_BITS];
   assign elapsed = now - last_close_ff;
   assign close   = (elapsed > pam_pkg::TIME_BITS'(window_ff));
   assign ctrl    = '{accept: accept, close: accept && close};
   assign all_done = &lane_done;

   for (genvar i = 0; i < pam_pkg::FIELD_COUNT; i++) begin : g_lane
      if (i < pam_pkg::CHANNELS) begin : g_used
         pam_pkg::lane_cfg_type cfg;
         assign cfg = '{divisor:          (i == 0) ? divisor_first_ff : divisor_other_ff,
                        midpoint:         midpoint_ff,
                        correction_limit: correction_ff,
                        floor_limit:      floor_ff};
         pam_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .sample    (req_tdata[i*pam_pkg::SAMPLE_BITS +: pam_pkg::SAMPLE_BITS]),
            .cfg       (cfg),
            .amplitude (amps[i]),
            .done      (lane_done[i])
         );
      end else begin : g_unused
         assign amps[i]      = '0;
         assign lane_done[i] = 1'b1;
      end
   end

   pam_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .amps       (amps),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pam_pkg::TOP_IDLE: if (accept && close) state_in = pam_pkg::TOP_BUSY;
         pam_pkg::TOP_BUSY: begin
            if (all_done) state_in = free ? pam_pkg::TOP_IDLE : pam_pkg::TOP_HOLD;
         end
         pam_pkg::TOP_HOLD: if (free) state_in = pam_pkg::TOP_IDLE;
         default:           state_in = pam_pkg::TOP_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == pam_pkg::TOP_IDLE);
      load       = ((state_ff == pam_pkg::TOP_BUSY) && all_done && free) ||
                   ((state_ff == pam_pkg::TOP_HOLD) && free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pam_pkg::TOP_IDLE;
         last_close_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && close) last_close_ff <= now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_first_ff <= pam_pkg::RST_DIVISOR_FIRST;
         divisor_other_ff <= pam_pkg::RST_DIVISOR_OTHER;
         midpoint_ff      <= pam_pkg::RST_PEAK_MIDPOINT;
         window_ff        <= pam_pkg::RST_WINDOW_MS;
         correction_ff    <= pam_pkg::RST_CORRECTION_LIMIT;
         floor_ff         <= pam_pkg::RST_FLOOR_LIMIT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pam_pkg::CSR_DIVISOR_FIRST:    divisor_first_ff <= csr_wdata;
            pam_pkg::CSR_DIVISOR_OTHER:    divisor_other_ff <= csr_wdata;
            pam_pkg::CSR_PEAK_MIDPOINT:    midpoint_ff   <= csr_wdata[pam_pkg::SAMPLE_BITS-1:0];
            pam_pkg::CSR_WINDOW_MS:        window_ff     <= csr_wdata;
            pam_pkg::CSR_CORRECTION_LIMIT: correction_ff <= csr_wdata[pam_pkg::AMP_BITS-1:0];
            pam_pkg::CSR_FLOOR_LIMIT:      floor_ff      <= csr_wdata[pam_pkg::AMP_BITS-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ----- rtl/core/pam_checker.sv -----
// Port-level checks of the amplitude meter, bound to the top level.
module pam_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [pam_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a window close in progress");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid))
      else $error("req_tready dropped without an accepted item");

endmodule

bind six_channel_peak_amplitude_meter_unit pam_checker u_pam_checker (.*);
